/* hdl/utdz_pkg.sv */
// ----------------------------------------------------------------------------
// utdz_pkg
// shared types, constants and small functions of the utc zone shift block
// ----------------------------------------------------------------------------
`default_nettype none

package utdz_pkg;

  localparam logic [7:0] AsciiZero     = 8'h30;
  localparam logic [7:0] AsciiNine     = 8'h39;
  localparam logic [7:0] HoursPerDay   = 8'd24;
  localparam logic [6:0] MonthsPerYear = 7'd12;
  localparam logic [6:0] LastYear      = 7'd99;
  localparam int unsigned OffsetW      = 5;
  localparam logic [OffsetW-1:0] OffsetReset = 5'd8;

  // raw input item, one ascii char per field
  typedef struct packed {
    logic [7:0] hour_tens_char;
    logic [7:0] hour_ones_char;
    logic [7:0] day_tens_char;
    logic [7:0] day_ones_char;
    logic [7:0] month_tens_char;
    logic [7:0] month_ones_char;
    logic [7:0] year_tens_char;
    logic [7:0] year_ones_char;
  } in_item_t;

  // decoded binary values plus error flag
  typedef struct packed {
    logic [6:0] hour;
    logic [6:0] day;
    logic [6:0] month;
    logic [6:0] year;
    logic       bad;
  } dec_t;

  // result item
  typedef struct packed {
    logic [5:0] local_hour_tens;
    logic [5:0] local_hour_ones;
    logic [5:0] local_day_tens;
    logic [5:0] local_day_ones;
    logic [5:0] local_month_tens;
    logic [5:0] local_month_ones;
    logic [5:0] local_year_tens;
    logic [5:0] local_year_ones;
    logic       date_advanced;
    logic       input_error;
  } res_t;

  // month length, month already known to be 1..12
  function automatic logic [4:0] month_len(logic [6:0] month, logic leap);
    logic [4:0] len;
    case (month[3:0])
      4'd2:    len = leap ? 5'd29 : 5'd28;
      4'd4:    len = 5'd30;
      4'd6:    len = 5'd30;
      4'd9:    len = 5'd30;
      4'd11:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

  // two ascii digits of a value 0..99, tens by reciprocal multiply
  function automatic logic [11:0] to_ascii_pair(logic [6:0] v);
    logic [13:0] prod;
    logic [3:0]  tens;
    logic [6:0]  tens_x10;
    logic [3:0]  ones;
    prod     = 14'(v) * 14'd103;
    tens     = prod[13:10];
    tens_x10 = 7'({tens, 3'b000}) + 7'({tens, 1'b0});
    ones     = 4'(v - tens_x10);
    return {2'b11, tens, 2'b11, ones};
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= AsciiZero) && (c <= AsciiNine);
  endfunction

endpackage

`default_nettype wire

/* hdl/utdz_in_if.sv */
// ----------------------------------------------------------------------------
// utdz_in_if
// valid/ready channel carrying one utc timestamp as ascii digit pairs
// ----------------------------------------------------------------------------
`default_nettype none

interface utdz_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] hour_tens_char;
  logic [7:0] hour_ones_char;
  logic [7:0] day_tens_char;
  logic [7:0] day_ones_char;
  logic [7:0] month_tens_char;
  logic [7:0] month_ones_char;
  logic [7:0] year_tens_char;
  logic [7:0] year_ones_char;

  modport source (
    output valid, hour_tens_char, hour_ones_char, day_tens_char, day_ones_char,
           month_tens_char, month_ones_char, year_tens_char, year_ones_char,
    input  ready
  );
  modport sink (
    input  valid, hour_tens_char, hour_ones_char, day_tens_char, day_ones_char,
           month_tens_char, month_ones_char, year_tens_char, year_ones_char,
    output ready
  );
endinterface

`default_nettype wire

/* hdl/utdz_out_if.sv */
// ----------------------------------------------------------------------------
// utdz_out_if
// valid/ready channel carrying the local time and date result
// ----------------------------------------------------------------------------
`default_nettype none

interface utdz_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] local_hour_tens;
  logic [5:0] local_hour_ones;
  logic [5:0] local_day_tens;
  logic [5:0] local_day_ones;
  logic [5:0] local_month_tens;
  logic [5:0] local_month_ones;
  logic [5:0] local_year_tens;
  logic [5:0] local_year_ones;
  logic       date_advanced;
  logic       input_error;

  modport source (
    output valid, local_hour_tens, local_hour_ones, local_day_tens, local_day_ones,
           local_month_tens, local_month_ones, local_year_tens, local_year_ones,
           date_advanced, input_error,
    input  ready
  );
  modport sink (
    input  valid, local_hour_tens, local_hour_ones, local_day_tens, local_day_ones,
           local_month_tens, local_month_ones, local_year_tens, local_year_ones,
           date_advanced, input_error,
    output ready
  );
endinterface

`default_nettype wire

/* hdl/utdz_decode.sv */
// ----------------------------------------------------------------------------
// utdz_decode
// checks the ascii digits and turns each pair into a binary value
// ----------------------------------------------------------------------------
`default_nettype none

module utdz_decode (
  input  utdz_pkg::in_item_t item_i,
  output utdz_pkg::dec_t     dec_o
);
  import utdz_pkg::*;

  logic [7:0] chars [8];
  logic [3:0] dig   [8];
  logic [7:0] ok;
  logic [6:0] val   [4];

  assign chars[0] = item_i.hour_tens_char;
  assign chars[1] = item_i.hour_ones_char;
  assign chars[2] = item_i.day_tens_char;
  assign chars[3] = item_i.day_ones_char;
  assign chars[4] = item_i.month_tens_char;
  assign chars[5] = item_i.month_ones_char;
  assign chars[6] = item_i.year_tens_char;
  assign chars[7] = item_i.year_ones_char;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      ok[i]  = is_digit(chars[i]);
      dig[i] = 4'(chars[i] - AsciiZero);
    end
    // tens * 10 + ones
    for (int p = 0; p < 4; p++) begin
      val[p] = 7'({dig[2*p], 3'b000}) + 7'({dig[2*p], 1'b0}) + 7'(dig[2*p+1]);
    end
  end

  assign dec_o.hour  = val[0];
  assign dec_o.day   = val[1];
  assign dec_o.month = val[2];
  assign dec_o.year  = val[3];
  assign dec_o.bad   = (ok != 8'hFF) || (val[2] == 7'd0) || (val[2] > MonthsPerYear);

endmodule

`default_nettype wire

/* hdl/utdz_calc.sv */
// ----------------------------------------------------------------------------
// utdz_calc
// zone shift, day/month/year rollover and ascii encoding of the result
// ----------------------------------------------------------------------------
`default_nettype none

module utdz_calc (
  input  utdz_pkg::in_item_t         item_i,
  input  utdz_pkg::dec_t             dec_i,
  input  logic [utdz_pkg::OffsetW-1:0] offset_i,
  output utdz_pkg::res_t             res_o
);
  import utdz_pkg::*;

  logic [7:0]  hsum;
  logic [7:0]  h1;
  logic [7:0]  h2;
  logic [7:0]  h3;
  logic        adv;
  logic [6:0]  day_inc;
  logic [4:0]  maxd;
  logic        over;
  logic [6:0]  day_n;
  logic [6:0]  month_n;
  logic [6:0]  year_n;
  logic        wrap_year;
  logic [11:0] p_hour;
  logic [11:0] p_day;
  logic [11:0] p_month;
  logic [11:0] p_year;

  // sum is at most 130, three conditional subtracts reduce it mod 24
  assign hsum = 8'(dec_i.hour) + 8'(offset_i);
  assign adv  = hsum >= HoursPerDay;
  assign h1   = (hsum >= 8'd96) ? hsum - 8'd96 : hsum;
  assign h2   = (h1 >= 8'd48) ? h1 - 8'd48 : h1;
  assign h3   = (h2 >= 8'd24) ? h2 - 8'd24 : h2;

  assign day_inc = dec_i.day + 7'(adv);
  // years 2000..2099: leap exactly when yy is a multiple of four
  assign maxd    = month_len(dec_i.month, dec_i.year[1:0] == 2'b00);
  assign over    = day_inc > 7'(maxd);

  assign wrap_year = over && (dec_i.month == MonthsPerYear);
  assign day_n     = over ? 7'd1 : day_inc;
  assign month_n   = wrap_year ? 7'd1 : (over ? dec_i.month + 7'd1 : dec_i.month);
  assign year_n    = !wrap_year ? dec_i.year :
                     ((dec_i.year >= LastYear) ? 7'd0 : dec_i.year + 7'd1);

  assign p_hour  = to_ascii_pair(h3[6:0]);
  assign p_day   = to_ascii_pair(day_n);
  assign p_month = to_ascii_pair(month_n);
  assign p_year  = to_ascii_pair(year_n);

  always_comb begin
    if (dec_i.bad) begin
      // pass the raw characters through
      res_o.local_hour_tens  = item_i.hour_tens_char[5:0];
      res_o.local_hour_ones  = item_i.hour_ones_char[5:0];
      res_o.local_day_tens   = item_i.day_tens_char[5:0];
      res_o.local_day_ones   = item_i.day_ones_char[5:0];
      res_o.local_month_tens = item_i.month_tens_char[5:0];
      res_o.local_month_ones = item_i.month_ones_char[5:0];
      res_o.local_year_tens  = item_i.year_tens_char[5:0];
      res_o.local_year_ones  = item_i.year_ones_char[5:0];
      res_o.date_advanced    = 1'b0;
      res_o.input_error      = 1'b1;
    end else begin
      res_o.local_hour_tens  = p_hour[11:6];
      res_o.local_hour_ones  = p_hour[5:0];
      res_o.local_day_tens   = p_day[11:6];
      res_o.local_day_ones   = p_day[5:0];
      res_o.local_month_tens = p_month[11:6];
      res_o.local_month_ones = p_month[5:0];
      res_o.local_year_tens  = p_year[11:6];
      res_o.local_year_ones  = p_year[5:0];
      res_o.date_advanced    = adv;
      res_o.input_error      = 1'b0;
    end
  end

endmodule

`default_nettype wire

/* hdl/utc_date_time_zone_shift_unit.sv */
// ----------------------------------------------------------------------------
// utc_date_time_zone_shift_unit
// shifts a utc hour/date stamp by a whole-hour zone offset with date rollover
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake      payload
//  --------  ---  -------------  -----------------------------------------
//  in_i      in   valid/ready    8 ascii chars: hh dd mm yy (utc)
//  out_o     out  valid/ready    8 x 6-bit ascii digits, date_advanced,
//                                input_error
//  cfg       in   cfg_we_i       cfg_wdata_i: zone offset in hours
//
//  one item per cycle sustained while the sink does not stall; an input item
//  passes the input register, then the result register, before result valid
//  input stage advances whenever the result register is empty or drained,
//  so a full result register only stalls input when the sink stalls too
//  rst_ni clears both valid flags and loads the zone offset with 8
//  offset must only be rewritten while no item is in flight
// ----------------------------------------------------------------------------
`default_nettype none

module utc_date_time_zone_shift_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  utdz_in_if.sink                       in_i,
  utdz_out_if.source                    out_o,
  input  logic                          cfg_we_i,
  input  logic [utdz_pkg::OffsetW-1:0]  cfg_wdata_i
);
  import utdz_pkg::*;

  logic [OffsetW-1:0] offset_q;
  logic               s1_valid_q;
  in_item_t           s1_item_q;
  in_item_t           in_item;
  logic               out_valid_q;
  res_t               out_res_q;
  dec_t               dec;
  res_t               res_d;
  logic               s1_adv;
  logic               in_xfer;

  // zone offset register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= OffsetReset;
    end else if (cfg_we_i) begin
      offset_q <= cfg_wdata_i;
    end
  end

  assign in_item.hour_tens_char  = in_i.hour_tens_char;
  assign in_item.hour_ones_char  = in_i.hour_ones_char;
  assign in_item.day_tens_char   = in_i.day_tens_char;
  assign in_item.day_ones_char   = in_i.day_ones_char;
  assign in_item.month_tens_char = in_i.month_tens_char;
  assign in_item.month_ones_char = in_i.month_ones_char;
  assign in_item.year_tens_char  = in_i.year_tens_char;
  assign in_item.year_ones_char  = in_i.year_ones_char;

  // stage 1 moves on when the result register is free or being taken
  assign s1_adv     = !out_valid_q || out_o.ready;
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_xfer    = in_i.valid && in_i.ready;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_item_q <= in_item;
    end
  end

  // date arithmetic between the two registers
  utdz_decode u_decode (
    .item_i (s1_item_q),
    .dec_o  (dec)
  );

  utdz_calc u_calc (
    .item_i   (s1_item_q),
    .dec_i    (dec),
    .offset_i (offset_q),
    .res_o    (res_d)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_valid_q) begin
      out_res_q <= res_d;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.local_hour_tens  = out_res_q.local_hour_tens;
  assign out_o.local_hour_ones  = out_res_q.local_hour_ones;
  assign out_o.local_day_tens   = out_res_q.local_day_tens;
  assign out_o.local_day_ones   = out_res_q.local_day_ones;
  assign out_o.local_month_tens = out_res_q.local_month_tens;
  assign out_o.local_month_ones = out_res_q.local_month_ones;
  assign out_o.local_year_tens  = out_res_q.local_year_tens;
  assign out_o.local_year_ones  = out_res_q.local_year_ones;
  assign out_o.date_advanced    = out_res_q.date_advanced;
  assign out_o.input_error      = out_res_q.input_error;

endmodule

`default_nettype wire

/* hdl/utdz_checker.sv */
// ----------------------------------------------------------------------------
// utdz_checker
// port-level checks of the zone shift unit, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module utdz_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [5:0] hour_tens_i,
  input logic [5:0] hour_ones_i,
  input logic [5:0] month_tens_i,
  input logic [5:0] month_ones_i,
  input logic       date_advanced_i,
  input logic       input_error_i
);

  // the two flags never come together
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(date_advanced_i && input_error_i))
    else $error("date_advanced and input_error both set");

  // a good result carries an hour of 00..23
  a_hour_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !input_error_i) |->
      ((hour_tens_i == 6'h30 || hour_tens_i == 6'h31) &&
       hour_ones_i >= 6'h30 && hour_ones_i <= 6'h39) ||
      (hour_tens_i == 6'h32 && hour_ones_i >= 6'h30 && hour_ones_i <= 6'h33))
    else $error("local hour out of range");

  // a good result carries a month of 01..12
  a_month_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !input_error_i) |->
      (month_tens_i == 6'h30 && month_ones_i >= 6'h31 && month_ones_i <= 6'h39) ||
      (month_tens_i == 6'h31 && month_ones_i >= 6'h30 && month_ones_i <= 6'h32))
    else $error("local month out of range");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(hour_tens_i) && $stable(hour_ones_i) &&
       $stable(month_tens_i) && $stable(month_ones_i) &&
       $stable(date_advanced_i) && $stable(input_error_i)))
    else $error("stalled result changed");

endmodule

bind utc_date_time_zone_shift_unit utdz_checker u_utdz_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .hour_tens_i     (out_o.local_hour_tens),
  .hour_ones_i     (out_o.local_hour_ones),
  .month_tens_i    (out_o.local_month_tens),
  .month_ones_i    (out_o.local_month_ones),
  .date_advanced_i (out_o.date_advanced),
  .input_error_i   (out_o.input_error)
);

`default_nettype wire
